[hdl/rrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_pkg
// Types and constants for the residue checker.
// ----------------------------------------------------------------------------
package rrc_pkg;

    localparam logic [7:0] TOK_CONCAT = 8'h2E;
    localparam logic [7:0] TOK_UNION  = 8'h2B;
    localparam logic [7:0] TOK_STAR   = 8'h2A;

    localparam logic [1:0] VERDICT_YES = 2'd0;
    localparam logic [1:0] VERDICT_NO  = 2'd1;
    localparam logic [1:0] VERDICT_ERR = 2'd2;

    typedef enum logic [1:0] {
        OP_LETTER,
        OP_CONCAT,
        OP_UNION,
        OP_STAR
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ1,
        ST_READ2,
        ST_CONCAT,
        ST_STAR_G,
        ST_STAR_D,
        ST_STAR_M,
        ST_PUSH,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_op;     // latch token and operands start
        logic rd_top;      // read stack at depth-1
        logic rd_next;     // read stack at depth-2
        logic cap_x;       // capture read data as x
        logic cap_y;       // capture read data as y
        logic cat_init;
        logic cat_step;
        logic star_init;
        logic gcd_step;    // one subtract step of gcd
        logic star_d_init;
        logic star_m_step;
        logic do_push;     // push result (or mark overflow)
        logic do_pop1;
        logic do_pop2;
        logic set_err;
        logic rd_verdict;
        logic end_expr;
    } rrc_cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic depth_lt1;
        logic depth_lt2;
        logic last;
        logic cat_done;
        logic gcd_done;
        logic star_m_done;
    } rrc_status_t;

endpackage
`default_nettype wire

[hdl/rrc_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface rrc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/rrc_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_datapath
// Set stack memory, operand registers, cyclic sum and star units.
// ----------------------------------------------------------------------------
module rrc_datapath #(
    parameter int MAX_MODULUS = 64,
    parameter int STACK_DEPTH = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [7:0]            token,
    input  wire                  last_token,
    input  wire [7:0]            counted_letter,
    input  wire [6:0]            modulus,
    input  rrc_pkg::rrc_cmd_t    cmd,
    output rrc_pkg::rrc_status_t status,
    output logic [1:0]           verdict
);
    import rrc_pkg::*;

    localparam int MW = MAX_MODULUS;
    localparam int KW = $clog2(MAX_MODULUS + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [MW-1:0] mem [STACK_DEPTH];
    logic [MW-1:0] rd_data_reg;
    logic [DW-1:0] depth_reg;
    logic          err_reg;
    op_t           op_reg;
    logic          last_reg;
    logic [KW-1:0] k_reg;
    logic [MW-1:0] kmask_reg;
    logic [MW-1:0] x_reg, y_reg, res_reg, rot_reg;
    logic [KW-1:0] idx_reg;
    logic [KW-1:0] ga_reg, gb_reg;

    logic [KW-1:0] k_eff;
    logic [MW-1:0] kmask;
    logic [AW-1:0] rd_addr;
    logic [MW-1:0] rot_next;
    logic [MW-1:0] y_cut;

    always_comb
    begin
        if (modulus == 7'd0)
            k_eff = KW'(1);
        else if (32'(modulus) > MAX_MODULUS)
            k_eff = KW'(MAX_MODULUS);
        else
            k_eff = KW'(modulus);
        for (int i = 0; i < MW; i++)
            kmask[i] = (i < 32'(k_eff));
    end

    // rotate left by one within k bits
    always_comb
    begin
        rot_next = (rot_reg << 1) & kmask_reg;
        for (int i = 0; i < MW; i++)
            if ((i + 1) == 32'(k_reg) && rot_reg[i])
                rot_next[0] = 1'b1;
    end

    assign y_cut = y_reg & kmask_reg;

    always_comb
    begin
        if (cmd.rd_next)
            rd_addr = AW'(depth_reg - DW'(2));
        else
            rd_addr = AW'(depth_reg - DW'(1));
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.do_push && !err_reg && 32'(depth_reg) < STACK_DEPTH)
            mem[AW'(depth_reg)] <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.end_expr)
            begin
                depth_reg <= '0;
                err_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.set_err)
                    err_reg <= 1'b1;
                if (cmd.do_pop2)
                    depth_reg <= depth_reg - DW'(2);
                else if (cmd.do_pop1)
                    depth_reg <= depth_reg - DW'(1);
                else if (cmd.do_push)
                begin
                    if (32'(depth_reg) < STACK_DEPTH)
                        depth_reg <= depth_reg + DW'(1);
                    else
                        err_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            last_reg  <= last_token;
            k_reg     <= k_eff;
            kmask_reg <= kmask;
            if (token == counted_letter)
            begin
                op_reg  <= OP_LETTER;
                res_reg <= (k_eff == KW'(1)) ? MW'(1) : MW'(2);
            end
            else if (token == TOK_CONCAT)
                op_reg <= OP_CONCAT;
            else if (token == TOK_UNION)
                op_reg <= OP_UNION;
            else if (token == TOK_STAR)
                op_reg <= OP_STAR;
            else
            begin
                op_reg  <= OP_LETTER;
                res_reg <= MW'(1);
            end
        end
        if (cmd.cap_x)
            x_reg <= rd_data_reg;
        if (cmd.cap_y)
        begin
            y_reg <= rd_data_reg;
            if (op_reg == OP_UNION)
                res_reg <= (x_reg | rd_data_reg) & kmask_reg;
        end
        if (cmd.cat_init)
        begin
            res_reg <= '0;
            rot_reg <= y_cut;
            idx_reg <= '0;
        end
        if (cmd.cat_step)
        begin
            if (x_reg[idx_reg[$clog2(MW)-1:0]] && 32'(idx_reg) < MW)
                res_reg <= res_reg | rot_reg;
            rot_reg <= rot_next;
            idx_reg <= idx_reg + KW'(1);
        end
        if (cmd.star_init)
        begin
            // gcd of nonzero members with k equals gcd over all members incl k
            ga_reg  <= k_reg;
            gb_reg  <= '0;
            idx_reg <= KW'(1);
            x_reg   <= x_reg & kmask_reg;
        end
        if (cmd.gcd_step)
        begin
            // subtraction gcd; absorbs next member when gb idle
            if (gb_reg == '0)
            begin
                if (32'(idx_reg) < 32'(k_reg) && x_reg[idx_reg[$clog2(MW)-1:0]])
                    gb_reg <= idx_reg;
                idx_reg <= idx_reg + KW'(1);
            end
            else if (ga_reg == gb_reg)
                gb_reg <= '0;
            else if (ga_reg > gb_reg)
                ga_reg <= ga_reg - gb_reg;
            else
                gb_reg <= gb_reg - ga_reg;
        end
        if (cmd.star_d_init)
        begin
            res_reg <= '0;
            idx_reg <= '0;
        end
        if (cmd.star_m_step)
        begin
            res_reg[idx_reg[$clog2(MW)-1:0]] <= 1'b1;
            idx_reg <= idx_reg + ga_reg;
        end
    end

    // without an error the last token has just pushed res_reg, so it is the top set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verdict <= VERDICT_ERR;
        else if (cmd.rd_verdict)
        begin
            if (err_reg || depth_reg == '0)
                verdict <= VERDICT_ERR;
            else
                verdict <= res_reg[0] ? VERDICT_YES : VERDICT_NO;
        end
    end

    always_comb
    begin
        status.op          = op_reg;
        status.err         = err_reg;
        status.depth_lt1   = (depth_reg == '0);
        status.depth_lt2   = (depth_reg < DW'(2));
        status.last        = last_reg;
        status.cat_done    = (idx_reg >= k_reg);
        status.gcd_done    = (gb_reg == '0) && (idx_reg >= k_reg);
        status.star_m_done = (idx_reg >= k_reg);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= STACK_DEPTH)
        else $error("stack depth beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_expr |=> depth_reg == '0 && !err_reg)
        else $error("expression end did not clear state");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop2 |-> $past(depth_reg) >= DW'(2) || depth_reg >= DW'(2))
        else $error("pop of two with short stack");
endmodule
`default_nettype wire

[hdl/rrc_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_controller
// Sequencer for token handling and verdict output.
// ----------------------------------------------------------------------------
module rrc_controller (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  rrc_pkg::rrc_status_t status,
    output rrc_pkg::rrc_cmd_t    cmd
);
    import rrc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = ST_READ1;
                end
            end
            ST_READ1:
            begin
                if (status.err)
                    state_next = ST_FINISH;
                else if (status.op == OP_LETTER)
                    state_next = ST_PUSH;
                else if (status.op == OP_STAR && status.depth_lt1)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (status.op != OP_STAR && status.depth_lt2)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.rd_top = 1'b1;
                    state_next = ST_READ2;
                end
            end
            ST_READ2:
            begin
                cmd.rd_next = 1'b1;
                cmd.cap_x   = 1'b1;
                if (status.op == OP_STAR)
                begin
                    cmd.do_pop1 = 1'b1;
                    state_next  = ST_STAR_G;
                end
                else
                    state_next = ST_CONCAT;
            end
            ST_CONCAT:
            begin
                cmd.cap_y   = 1'b1;
                cmd.do_pop2 = 1'b1;
                if (status.op == OP_CONCAT)
                begin
                    state_next = ST_STAR_D;
                end
                else
                    state_next = ST_PUSH;
            end
            ST_STAR_G:
            begin
                if (status.op == OP_STAR)
                begin
                    cmd.star_init = 1'b1;
                    state_next    = ST_STAR_M;
                end
                else
                begin
                    cmd.cat_step = 1'b1;
                    if (status.cat_done)
                    begin
                        cmd.cat_step = 1'b0;
                        state_next   = ST_PUSH;
                    end
                end
            end
            ST_STAR_D:
            begin
                cmd.cat_init = 1'b1;
                state_next   = ST_STAR_G;
            end
            ST_STAR_M:
            begin
                if (status.gcd_done)
                begin
                    cmd.star_d_init = 1'b1;
                    state_next      = ST_OUT;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            ST_OUT:
            begin
                if (status.star_m_done)
                    state_next = ST_PUSH;
                else
                    cmd.star_m_step = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.do_push = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // last token waits here until the verdict register is free
                if (status.last)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.rd_verdict = 1'b1;
                        cmd.end_expr   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_op |-> state_reg == ST_IDLE)
        else $error("token taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_push |=> state_reg == ST_FINISH)
        else $error("push not followed by finish");
endmodule
`default_nettype wire

[hdl/rpn_regex_residue_checker_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_regex_residue_checker_top
// Postfix regex residue checker: one token per transfer, verdict on the last.
// ----------------------------------------------------------------------------
// A letter token is pushed without reading the stack; union reads two sets and
// a token skipped after an error or failing on underflow pushes nothing.
// Concatenation does one rotation of the operand per cycle. Star runs a
// subtractive gcd over the set's members, d being the resulting gcd, and
// then marks the multiples of d. One token is in flight at a time; the
// verdict is registered and further tokens are taken while it waits, a last
// token holding in its final state until the earlier verdict has been taken.
module rpn_regex_residue_checker_top #(
    parameter int MAX_MODULUS = 64,
    parameter int STACK_DEPTH = 32
) (
    input  wire  clk,
    input  wire  rst_n,
    rrc_stream_if.sink   in_ch,
    rrc_stream_if.source out_ch,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [0:0] cfg_index,
    input  wire  [7:0] cfg_data
);
    import rrc_pkg::*;

    localparam logic [0:0] REG_LETTER  = 1'b0;
    localparam logic [0:0] REG_MODULUS = 1'b1;

    logic [7:0]  counted_letter_reg;
    logic [6:0]  modulus_reg;
    rrc_cmd_t    cmd;
    rrc_status_t status;
    logic [1:0]  verdict;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counted_letter_reg <= 8'd97;
            modulus_reg        <= 7'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LETTER:  counted_letter_reg <= cfg_data;
                REG_MODULUS: modulus_reg        <= cfg_data[6:0];
                default:     ;
            endcase
        end
    end

    rrc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rrc_datapath #(
        .MAX_MODULUS (MAX_MODULUS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .token          (in_ch.payload[8:1]),
        .last_token     (in_ch.payload[0]),
        .counted_letter (counted_letter_reg),
        .modulus        (modulus_reg),
        .cmd            (cmd),
        .status         (status),
        .verdict        (verdict)
    );

    assign out_ch.payload = verdict;
endmodule
`default_nettype wire
